### design/cpd_pkg.sv
// shared types and constants for the checksum packet deframer
package cpd_pkg;

    localparam logic [15:0] SYNC_WORD_RESET = 16'hFEFF;
    localparam logic        SIGN_EXT_RESET  = 1'b1;
    localparam logic [15:0] MIN_LENGTH      = 16'd4;

    localparam logic REG_SYNC_WORD = 1'b0;
    localparam logic REG_SIGN_EXT  = 1'b1;

    localparam logic [1:0] STATUS_GOOD  = 2'd0;
    localparam logic [1:0] STATUS_BAD   = 2'd1;
    localparam logic [1:0] STATUS_SHORT = 2'd2;

    typedef enum logic [4:0] {
        PH_HUNT = 5'b00001,
        PH_CMD  = 5'b00010,
        PH_LEN  = 5'b00100,
        PH_SUM  = 5'b01000,
        PH_DATA = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [15:0] sync_word;
        logic        sign_extend_bytes;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        frame_end;
        logic [15:0] command;
        logic [1:0]  status;
    } result_t;

endpackage

### design/checksum_packet_deframer.sv
// top level: byte-stream deframer with sync hunt, length and additive checksum
// One byte is taken every clock cycle while s_tready is high, with no gaps between
// frames or bytes; the parser updates its frame state in the same cycle it takes a
// byte and any result is written into a two-entry output buffer, so s_tready drops
// only when both buffer entries hold results that the sink has not yet taken. While
// the sink keeps up, a payload byte is registered into the entry driving m_tdata;
// otherwise it waits behind the beat already in the buffer. The beat carrying the
// last payload byte (or the last checksum byte for an empty payload, or the second
// length byte for a length below 4) has m_tlast set and the status in m_tuser.
module checksum_packet_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] payload_byte, [23:8] command
    output logic        m_tlast,
    output logic [2:0]  m_tuser,   // [0] payload_valid, [2:1] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cpd_pkg::cfg_t    cfg_reg;
    cpd_pkg::result_t res;
    cpd_pkg::result_t out_res;
    logic             res_valid;
    logic             step;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign step      = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_word         <= cpd_pkg::SYNC_WORD_RESET;
            cfg_reg.sign_extend_bytes <= cpd_pkg::SIGN_EXT_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                cpd_pkg::REG_SYNC_WORD: cfg_reg.sync_word         <= pwdata[15:0];
                cpd_pkg::REG_SIGN_EXT:  cfg_reg.sign_extend_bytes <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            cpd_pkg::REG_SYNC_WORD: prdata = {16'd0, cfg_reg.sync_word};
            cpd_pkg::REG_SIGN_EXT:  prdata = {31'd0, cfg_reg.sign_extend_bytes};
            default:                prdata = 32'd0;
        endcase
    end

    cpd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .in_byte   (s_tdata),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    cpd_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {out_res.command, out_res.payload_byte};
    assign m_tlast = out_res.frame_end;
    assign m_tuser = {out_res.status, out_res.payload_valid};

    // input stalls only while results are waiting
    a_stall_has_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

    // a nonzero status only on the closing beat
    a_status_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[2:1] == cpd_pkg::STATUS_GOOD)
        else $error("status set on a beat that does not close a frame");

    // a beat without payload closes a frame and carries a zero byte
    a_no_payload_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata[7:0] == 8'd0)
        else $error("beat without payload is not a frame end");

    // short-length status never comes with a payload byte
    a_short_no_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:1] == cpd_pkg::STATUS_SHORT |-> !m_tuser[0])
        else $error("short-length status on a payload beat");

endmodule

### design/cpd_parser.sv
// frame parser: sync hunt, header capture, payload checksum
module cpd_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        in_byte,
    input  cpd_pkg::cfg_t     cfg,
    output logic              res_valid,
    output cpd_pkg::result_t  res
);

    cpd_pkg::phase_t phase_reg, phase_next;
    logic        last_low_reg, last_low_next;
    logic [1:0]  idx_reg, idx_next;
    logic [15:0] cmd_reg, cmd_next;
    logic [15:0] len_reg, len_next;
    logic [31:0] exp_reg, exp_next;
    logic [31:0] sum_reg, sum_next;
    logic [15:0] remain_reg, remain_next;

    logic [15:0] len_full;
    logic [31:0] exp_full;
    logic [31:0] addend;
    logic [31:0] sum_add;
    logic [15:0] remain_dec;

    assign len_full   = {in_byte, len_reg[7:0]};
    assign exp_full   = {in_byte, exp_reg[23:0]};
    assign addend     = {{24{cfg.sign_extend_bytes & in_byte[7]}}, in_byte};
    assign sum_add    = sum_reg + addend;
    assign remain_dec = remain_reg - 16'd1;

    always_comb begin
        phase_next    = phase_reg;
        last_low_next = last_low_reg;
        idx_next      = idx_reg;
        cmd_next      = cmd_reg;
        len_next      = len_reg;
        exp_next      = exp_reg;
        sum_next      = sum_reg;
        remain_next   = remain_reg;
        res_valid     = 1'b0;
        res.payload_byte  = 8'd0;
        res.payload_valid = 1'b0;
        res.frame_end     = 1'b0;
        res.command       = cmd_reg;
        res.status        = cpd_pkg::STATUS_GOOD;
        unique case (phase_reg)
            cpd_pkg::PH_HUNT: begin
                if (last_low_reg && in_byte == cfg.sync_word[15:8]) begin
                    last_low_next = 1'b0;
                    phase_next    = cpd_pkg::PH_CMD;
                    idx_next      = 2'd0;
                    cmd_next      = 16'd0;
                    len_next      = 16'd0;
                    exp_next      = 32'd0;
                    sum_next      = 32'd0;
                    remain_next   = 16'd0;
                end else begin
                    last_low_next = (in_byte == cfg.sync_word[7:0]);
                end
            end
            cpd_pkg::PH_CMD: begin
                if (idx_reg[0]) begin
                    cmd_next[15:8] = in_byte;
                    idx_next       = 2'd0;
                    phase_next     = cpd_pkg::PH_LEN;
                end else begin
                    cmd_next[7:0] = in_byte;
                    idx_next      = 2'd1;
                end
            end
            cpd_pkg::PH_LEN: begin
                if (idx_reg[0]) begin
                    len_next = len_full;
                    idx_next = 2'd0;
                    if (len_full < cpd_pkg::MIN_LENGTH) begin
                        phase_next    = cpd_pkg::PH_HUNT;
                        last_low_next = 1'b0;
                        res_valid     = 1'b1;
                        res.frame_end = 1'b1;
                        res.status    = cpd_pkg::STATUS_SHORT;
                    end else begin
                        phase_next = cpd_pkg::PH_SUM;
                    end
                end else begin
                    len_next[7:0] = in_byte;
                    idx_next      = 2'd1;
                end
            end
            cpd_pkg::PH_SUM: begin
                case (idx_reg)
                    2'd0:    exp_next[7:0]   = in_byte;
                    2'd1:    exp_next[15:8]  = in_byte;
                    2'd2:    exp_next[23:16] = in_byte;
                    default: exp_next[31:24] = in_byte;
                endcase
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3) begin
                    remain_next = len_reg - cpd_pkg::MIN_LENGTH;
                    sum_next    = 32'd0;
                    if (len_reg == cpd_pkg::MIN_LENGTH) begin
                        phase_next    = cpd_pkg::PH_HUNT;
                        last_low_next = 1'b0;
                        res_valid     = 1'b1;
                        res.frame_end = 1'b1;
                        res.status    = (exp_full == 32'd0) ? cpd_pkg::STATUS_GOOD
                                                            : cpd_pkg::STATUS_BAD;
                    end else begin
                        phase_next = cpd_pkg::PH_DATA;
                    end
                end
            end
            cpd_pkg::PH_DATA: begin
                sum_next          = sum_add;
                remain_next       = remain_dec;
                res_valid         = 1'b1;
                res.payload_byte  = in_byte;
                res.payload_valid = 1'b1;
                if (remain_dec == 16'd0) begin
                    phase_next    = cpd_pkg::PH_HUNT;
                    last_low_next = 1'b0;
                    res.frame_end = 1'b1;
                    res.status    = (sum_add == exp_reg) ? cpd_pkg::STATUS_GOOD
                                                         : cpd_pkg::STATUS_BAD;
                end
            end
            default: begin
                phase_next    = cpd_pkg::PH_HUNT;
                last_low_next = 1'b0;
                idx_next      = 2'd0;
            end
        endcase
        if (!step) begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= cpd_pkg::PH_HUNT;
            last_low_reg <= 1'b0;
            idx_reg      <= 2'd0;
            cmd_reg      <= 16'd0;
            len_reg      <= 16'd0;
            exp_reg      <= 32'd0;
            sum_reg      <= 32'd0;
            remain_reg   <= 16'd0;
        end else if (step) begin
            phase_reg    <= phase_next;
            last_low_reg <= last_low_next;
            idx_reg      <= idx_next;
            cmd_reg      <= cmd_next;
            len_reg      <= len_next;
            exp_reg      <= exp_next;
            sum_reg      <= sum_next;
            remain_reg   <= remain_next;
        end
    end

endmodule

### design/cpd_skid.sv
// two-entry result buffer between the parser and the output stream
module cpd_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  cpd_pkg::result_t  in_data,
    output logic              in_ready,
    output logic              out_valid,
    output cpd_pkg::result_t  out_data,
    input  logic              out_ready
);

    logic             main_valid_reg, main_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    cpd_pkg::result_t main_data_reg, main_data_next;
    cpd_pkg::result_t skid_data_reg, skid_data_next;
    logic             take;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;
    assign take      = main_valid_reg && out_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (take) begin
            if (skid_valid_reg) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = 1'b0;
            end
        end
        if (in_valid) begin
            if (!main_valid_next) begin
                main_data_next  = in_data;
                main_valid_next = 1'b1;
            end else begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

### test/checksum_packet_deframer_tb.sv
// self-checking testbench for the checksum packet deframer: byte stream in, checked beats out
`timescale 1ns / 1ps

module checksum_packet_deframer_tb;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] in_byte
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [23:0] m_tdata;            // [7:0] payload_byte, [23:8] command
    logic        m_tlast;
    logic [2:0]  m_tuser;            // [0] payload_valid, [2:1] status
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    checksum_packet_deframer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // deframer model state
    cpd_pkg::cfg_t   cfg_model;
    cpd_pkg::phase_t frame_phase;
    logic        low_seen;
    logic [1:0]  field_idx;
    logic [15:0] cmd_word;
    logic [15:0] len_word;
    logic [31:0] sum_expected;
    logic [31:0] sum_running;
    logic [15:0] remaining;

    cpd_pkg::result_t expected_beats[$];
    logic [7:0]  frame_body[$];

    int mismatches    = 0;
    int bytes_sent    = 0;
    int beats_checked = 0;
    int frames_good   = 0;
    int frames_bad    = 0;
    int frames_short  = 0;
    bit src_gaps      = 1'b1;
    bit sink_stalls   = 1'b1;
    bit hold_sink     = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] body_sum();
        logic [31:0] acc;
        acc = 32'd0;
        foreach (frame_body[i]) begin
            if (cfg_model.sign_extend_bytes && frame_body[i][7])
                acc = acc + {24'hFFFFFF, frame_body[i]};
            else
                acc = acc + {24'h000000, frame_body[i]};
        end
        return acc;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic push_beat(input logic [7:0] data, input logic valid, input logic last,
                             input logic [1:0] st);
        cpd_pkg::result_t beat;
        beat.payload_byte  = data;
        beat.payload_valid = valid;
        beat.frame_end     = last;
        beat.command       = cmd_word;
        beat.status        = st;
        expected_beats.push_back(beat);
    endtask

    task automatic reset_model();
        cfg_model.sync_word         = cpd_pkg::SYNC_WORD_RESET;
        cfg_model.sign_extend_bytes = cpd_pkg::SIGN_EXT_RESET;
        frame_phase  = cpd_pkg::PH_HUNT;
        low_seen     = 1'b0;
        field_idx    = 2'd0;
        cmd_word     = 16'd0;
        len_word     = 16'd0;
        sum_expected = 32'd0;
        sum_running  = 32'd0;
        remaining    = 16'd0;
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        int          sh;
        logic [31:0] addend;
        logic [1:0]  st;
        sh = field_idx * 8;
        case (frame_phase)
            cpd_pkg::PH_HUNT: begin
                if (low_seen && b == cfg_model.sync_word[15:8]) begin
                    low_seen     = 1'b0;
                    frame_phase  = cpd_pkg::PH_CMD;
                    field_idx    = 2'd0;
                    cmd_word     = 16'd0;
                    len_word     = 16'd0;
                    sum_expected = 32'd0;
                    sum_running  = 32'd0;
                    remaining    = 16'd0;
                end else begin
                    low_seen = (b == cfg_model.sync_word[7:0]);
                end
            end
            cpd_pkg::PH_CMD: begin
                cmd_word = cmd_word | (16'(b) << sh);
                if (field_idx == 2'd1) begin
                    field_idx   = 2'd0;
                    frame_phase = cpd_pkg::PH_LEN;
                end else begin
                    field_idx = 2'd1;
                end
            end
            cpd_pkg::PH_LEN: begin
                len_word = len_word | (16'(b) << sh);
                if (field_idx == 2'd1) begin
                    field_idx = 2'd0;
                    if (len_word < cpd_pkg::MIN_LENGTH) begin
                        frame_phase = cpd_pkg::PH_HUNT;
                        low_seen    = 1'b0;
                        push_beat(8'h00, 1'b0, 1'b1, cpd_pkg::STATUS_SHORT);
                    end else begin
                        frame_phase = cpd_pkg::PH_SUM;
                    end
                end else begin
                    field_idx = 2'd1;
                end
            end
            cpd_pkg::PH_SUM: begin
                sum_expected = sum_expected | (32'(b) << sh);
                if (field_idx == 2'd3) begin
                    field_idx   = 2'd0;
                    remaining   = len_word - cpd_pkg::MIN_LENGTH;
                    sum_running = 32'd0;
                    if (remaining == 16'd0) begin
                        frame_phase = cpd_pkg::PH_HUNT;
                        low_seen    = 1'b0;
                        st = (sum_running == sum_expected) ? cpd_pkg::STATUS_GOOD
                                                           : cpd_pkg::STATUS_BAD;
                        push_beat(8'h00, 1'b0, 1'b1, st);
                    end else begin
                        frame_phase = cpd_pkg::PH_DATA;
                    end
                end else begin
                    field_idx = field_idx + 2'd1;
                end
            end
            cpd_pkg::PH_DATA: begin
                addend = (cfg_model.sign_extend_bytes && b[7]) ? {24'hFFFFFF, b}
                                                               : {24'h000000, b};
                sum_running = sum_running + addend;
                remaining   = remaining - 16'd1;
                if (remaining == 16'd0) begin
                    frame_phase = cpd_pkg::PH_HUNT;
                    low_seen    = 1'b0;
                    st = (sum_running == sum_expected) ? cpd_pkg::STATUS_GOOD
                                                       : cpd_pkg::STATUS_BAD;
                    push_beat(b, 1'b1, 1'b1, st);
                end else begin
                    push_beat(b, 1'b1, 1'b0, cpd_pkg::STATUS_GOOD);
                end
            end
            default: begin
                frame_phase = cpd_pkg::PH_HUNT;
                low_seen    = 1'b0;
                field_idx   = 2'd0;
            end
        endcase
    endtask

    // result checker
    always @(posedge aclk) begin
        cpd_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                report_mismatch("unexpected beat", {5'd0, m_tuser, m_tdata}, 32'd0);
            end else begin
                want = expected_beats.pop_front();
                beats_checked++;
                if (m_tdata[7:0] !== want.payload_byte)
                    report_mismatch("payload_byte", 32'(m_tdata[7:0]),
                                    32'(want.payload_byte));
                if (m_tuser[0] !== want.payload_valid)
                    report_mismatch("payload_valid", 32'(m_tuser[0]),
                                    32'(want.payload_valid));
                if (m_tlast !== want.frame_end)
                    report_mismatch("frame_end", 32'(m_tlast), 32'(want.frame_end));
                if (m_tdata[23:8] !== want.command)
                    report_mismatch("command", 32'(m_tdata[23:8]), 32'(want.command));
                if (m_tuser[2:1] !== want.status)
                    report_mismatch("status", 32'(m_tuser[2:1]), 32'(want.status));
                if (want.frame_end) begin
                    case (want.status)
                        cpd_pkg::STATUS_GOOD: frames_good++;
                        cpd_pkg::STATUS_BAD:  frames_bad++;
                        default:              frames_short++;
                    endcase
                end
            end
        end
    end

    // sink side: random stalls unless held or switched off
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                m_tready <= 1'b0;
            end else if (!sink_stalls) begin
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                stall_left = idle_len();
            end
        end
    end

    task automatic send_byte(input logic [7:0] value);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        deframe_byte(value);
        bytes_sent++;
        gap = src_gaps ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // sync, header and frame_body, stopping after cut bytes
    task automatic send_frame(input logic [15:0] cmd, input logic [15:0] len,
                              input logic [31:0] sum, input int cut);
        logic [7:0] wire_bytes[$];
        wire_bytes = {cfg_model.sync_word[7:0], cfg_model.sync_word[15:8],
                      cmd[7:0], cmd[15:8], len[7:0], len[15:8],
                      sum[7:0], sum[15:8], sum[23:16], sum[31:24]};
        foreach (frame_body[i]) wire_bytes.push_back(frame_body[i]);
        foreach (wire_bytes[i]) begin
            if (i < cut) send_byte(wire_bytes[i]);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        logic [31:0] want;
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            cpd_pkg::REG_SYNC_WORD: cfg_model.sync_word = value[15:0];
            default:                cfg_model.sign_extend_bytes = value[0];
        endcase
        want = (idx == cpd_pkg::REG_SYNC_WORD) ? {16'd0, cfg_model.sync_word}
                                               : {31'd0, cfg_model.sign_extend_bytes};
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (idx == cpd_pkg::REG_SYNC_WORD && prdata[15:0] !== want[15:0])
            report_mismatch("sync_word readback", prdata, want);
        if (idx == cpd_pkg::REG_SIGN_EXT && prdata[0] !== want[0])
            report_mismatch("sign_extend_bytes readback", prdata, want);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_short_length();
        frame_body.delete();
        // repeated sync low byte before the real sync word
        send_byte(cfg_model.sync_word[7:0]);
        send_frame(16'h1234, 16'd3, 32'd0, 6);
    endtask

    task automatic test_empty_payload();
        frame_body.delete();
        send_frame(16'hFFFF, cpd_pkg::MIN_LENGTH, 32'h0000_0001, 10);
    endtask

    task automatic test_payload_extremes();
        frame_body = {8'h00, 8'h7F, 8'h80, 8'hFF};
        send_frame(16'h0000, 16'd8, body_sum(), 14);
    endtask

    task automatic send_random_frame();
        int          kind;
        int          n;
        int          r;
        logic [15:0] len;
        logic [31:0] sum;
        if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                if ($urandom_range(0, 4) == 0) send_byte(cfg_model.sync_word[7:0]);
                else send_byte(8'($urandom_range(0, 255)));
            end
        end
        kind = $urandom_range(0, 99);
        r    = $urandom_range(0, 99);
        if (r < 85)      len = 16'($urandom_range(4, 24));
        else if (r < 97) len = 16'($urandom_range(25, 80));
        else             len = 16'($urandom_range(200, 300));
        frame_body.delete();
        if (kind < 8) begin
            send_frame(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 3)), 32'd0, 6);
            return;
        end
        repeat (len - cpd_pkg::MIN_LENGTH) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0: frame_body.push_back(8'h00);
                    1: frame_body.push_back(8'h7F);
                    2: frame_body.push_back(8'h80);
                    default: frame_body.push_back(8'hFF);
                endcase
            end else begin
                frame_body.push_back(8'($urandom_range(0, 255)));
            end
        end
        sum = body_sum();
        if ($urandom_range(0, 3) == 0) sum = sum ^ (32'h1 << $urandom_range(0, 31));
        if (kind < 14)
            send_frame(16'($urandom_range(0, 65535)), len, sum,
                       $urandom_range(2, len + 5));
        else
            send_frame(16'($urandom_range(0, 65535)), len, sum, len + 6);
    endtask

    task automatic test_random_frames(input logic [15:0] sync, input logic sign,
                                      input int quota, input bit gaps, input bit stalls);
        int start;
        write_reg(cpd_pkg::REG_SYNC_WORD, {16'd0, sync});
        write_reg(cpd_pkg::REG_SIGN_EXT, {31'd0, sign});
        src_gaps    = gaps;
        sink_stalls = stalls;
        start       = bytes_sent;
        while (bytes_sent - start < quota) send_random_frame();
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
    endtask

    task automatic test_sink_backpressure();
        wait_drained();
        hold_sink = 1'b1;
        frame_body = {8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66};
        fork
            send_frame(16'h5A5A, 16'd10, body_sum(), 16);
            begin
                while (s_tready) @(posedge aclk);
                hold_sink = 1'b0;
            end
        join
        // sender holds off until the whole frame has drained
        wait_drained();
        send_random_frame();
    endtask

    initial begin
        reset_model();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_short_length();
        test_empty_payload();
        test_payload_extremes();
        test_sink_backpressure();
        test_random_frames(cpd_pkg::SYNC_WORD_RESET, 1'b1, 400, 1'b1, 1'b1);
        test_random_frames(16'h0000, 1'b0, 250, 1'b1, 1'b1);
        test_random_frames(16'hFFFF, 1'b1, 250, 1'b1, 1'b1);
        test_random_frames(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                           300, 1'b1, 1'b1);
        test_random_frames(16'hA55A, 1'b0, 250, 1'b0, 1'b0);
        test_random_frames(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                           350, 1'b1, 1'b1);

        wait_drained();
        repeat (16) @(posedge aclk);
        $display("run: %0d bytes sent, %0d beats checked over six register settings",
                 bytes_sent, beats_checked);
        $display("frames closed: %0d checksum good, %0d checksum bad, %0d length short",
                 frames_good, frames_bad, frames_short);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
